[rtl/core/bmp24_crop_to_rgb565_top_defines.svh]
// ----------------------------------------------------------------------------
// bmp24_crop_to_rgb565 assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BMP24_CROP_TO_RGB565_TOP_DEFINES_SVH
`define BMP24_CROP_TO_RGB565_TOP_DEFINES_SVH

// same-cycle implication
`define BCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bcr_pkg.sv]
// ----------------------------------------------------------------------------
// bcr_pkg
// Types, constants and helpers shared by the BMP to RGB565 converter.
// ----------------------------------------------------------------------------
package bcr_pkg;

    localparam int unsigned MAX_IMAGE_DIM = 4096;

    localparam logic [7:0]  MAGIC_B     = 8'h42;
    localparam logic [7:0]  MAGIC_M     = 8'h4D;
    localparam logic [15:0] DEPTH_BGR24 = 16'd24;

    // last byte of each header field
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_DEPTH_END  = 32'd29;
    localparam logic [31:0] POS_COMP_END   = 32'd33;
    localparam logic [31:0] POS_HEADER_END = 32'd53;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL,
        KIND_NOT_BMP,
        KIND_UNSUPPORTED
    } t_kind;

    typedef enum logic {
        REG_DISPLAY_WIDTH,
        REG_DISPLAY_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] pixel_color;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        end_of_image;
    } t_out;

    typedef struct packed {
        logic [12:0] display_width;
        logic [12:0] display_height;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        end_of_image;
    } t_op;

    function automatic logic dim_bad(input logic [31:0] v);
        return (v == 32'd0) || v[31] || (v > 32'(MAX_IMAGE_DIM));
    endfunction

    function automatic logic [15:0] to_rgb565(input logic [7:0] red,
                                              input logic [7:0] green,
                                              input logic [7:0] blue);
        return {red[7:3], green[7:2], blue[7:3]};
    endfunction

endpackage

[rtl/core/bcr_cfg.sv]
// ----------------------------------------------------------------------------
// bcr_cfg
// APB register file holding the display area size.
// ----------------------------------------------------------------------------
module bcr_cfg
    import bcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [12:0] r_display_width;
    logic [12:0] r_display_height;
    t_reg_idx    reg_idx;
    logic        wr_en;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_width  <= 13'd320;
            r_display_height <= 13'd240;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DISPLAY_WIDTH:  r_display_width  <= pwdata[12:0];
                REG_DISPLAY_HEIGHT: r_display_height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DISPLAY_WIDTH:  prdata = {19'd0, r_display_width};
            REG_DISPLAY_HEIGHT: prdata = {19'd0, r_display_height};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg.display_width  = r_display_width;
    assign o_cfg.display_height = r_display_height;

endmodule

[rtl/core/bcr_front.sv]
// ----------------------------------------------------------------------------
// bcr_front
// Byte parser: header capture, skip, row walk and crop classification.
// ----------------------------------------------------------------------------
`include "bmp24_crop_to_rgb565_top_defines.svh"

module bcr_front
    import bcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output logic o_op_valid,
    output t_op  o_op
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_pix_off, n_pix_off;
    logic [12:0] r_width, n_width;
    logic [12:0] r_height, n_height;
    logic        r_depth_ok, n_depth_ok;
    logic        r_comp_ok, n_comp_ok;
    logic        r_size_bad, n_size_bad;
    logic [11:0] r_c0, n_c0;
    logic [12:0] r_c1p1, n_c1p1;
    logic [11:0] r_xoff, n_xoff;
    logic [11:0] r_r0, n_r0;
    logic [12:0] r_r1p1, n_r1p1;
    logic [11:0] r_yoff, n_yoff;
    logic [13:0] r_w3, n_w3;
    logic [13:0] r_row_bytes, n_row_bytes;
    logic [13:0] r_bir, n_bir;
    logic [1:0]  r_bip, n_bip;
    logic [11:0] r_col, n_col;
    logic [11:0] r_row_rev, n_row_rev;
    logic [7:0]  r_blue, n_blue;
    logic [7:0]  r_green, n_green;

    t_phase      eff_phase;
    logic [31:0] eff_pos;
    logic [7:0]  b;
    logic        magic_bad;
    logic        hdr_last;
    logic        hdr_bad;
    logic        skip_wait;
    logic        pix_mode;
    logic        in_data;
    logic        keep;
    logic        row_end;
    logic [13:0] bir_inc;
    logic        op_emit;

    logic [12:0] bx_dx, by_dy;
    logic [11:0] bx_x0, bx_c0, by_y0, by_r0;
    logic [12:0] bx_c1p1, by_r1p1;
    logic [13:0] w3_calc;

    assign b         = i_item.file_byte;
    assign eff_phase = i_item.start_of_file ? PH_MAGIC : r_phase;
    assign eff_pos   = i_item.start_of_file ? 32'd0 : r_pos;
    assign magic_bad = (eff_phase == PH_MAGIC) &&
                       (b != ((eff_pos == 32'd0) ? MAGIC_B : MAGIC_M));
    assign hdr_last  = (eff_phase == PH_HEADER) && (r_pos == POS_HEADER_END);
    assign hdr_bad   = !r_depth_ok || !r_comp_ok || r_size_bad;
    assign skip_wait = r_pos < r_pix_off;
    assign pix_mode  = (eff_phase == PH_PIXEL) || ((eff_phase == PH_SKIP) && !skip_wait);
    assign in_data   = r_bir < r_w3;
    assign bir_inc   = r_bir + 14'd1;
    assign row_end   = bir_inc == r_row_bytes;
    assign keep      = (r_col >= r_c0) && ({1'b0, r_col} < r_c1p1) &&
                       (r_row_rev >= r_r0) && ({1'b0, r_row_rev} < r_r1p1);

    // centering / cropping window for the captured image size
    always_comb begin
        if (i_cfg.display_width >= r_width) begin
            bx_dx   = i_cfg.display_width - r_width;
            bx_x0   = bx_dx[12:1];
            bx_c0   = 12'd0;
            bx_c1p1 = r_width;
        end else begin
            bx_dx   = r_width - i_cfg.display_width;
            bx_x0   = 12'd0;
            bx_c0   = bx_dx[12:1];
            bx_c1p1 = {1'b0, bx_c0} + i_cfg.display_width;
        end
        if (i_cfg.display_height >= r_height) begin
            by_dy   = i_cfg.display_height - r_height;
            by_y0   = by_dy[12:1];
            by_r0   = 12'd0;
            by_r1p1 = r_height;
        end else begin
            by_dy   = r_height - i_cfg.display_height;
            by_y0   = 12'd0;
            by_r0   = by_dy[12:1];
            by_r1p1 = {1'b0, by_r0} + i_cfg.display_height;
        end
        w3_calc = {1'b0, r_width} + {r_width, 1'b0};
    end

    // next state
    always_comb begin
        n_phase = eff_phase;
        case (eff_phase)
            PH_MAGIC: begin
                if (magic_bad) begin
                    n_phase = PH_DONE;
                end else if (eff_pos != 32'd0) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (hdr_last) begin
                    n_phase = hdr_bad ? PH_DONE : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (!skip_wait) begin
                    n_phase = (row_end && (r_row_rev == 12'd0)) ? PH_DONE : PH_PIXEL;
                end
            end
            PH_PIXEL: begin
                if (row_end && (r_row_rev == 12'd0)) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE:  n_phase = PH_DONE;
            default:  n_phase = PH_MAGIC;
        endcase
    end

    // datapath and beat out
    always_comb begin
        n_pos       = eff_pos;
        n_shift     = r_shift;
        n_pix_off   = r_pix_off;
        n_width     = r_width;
        n_height    = r_height;
        n_depth_ok  = r_depth_ok;
        n_comp_ok   = r_comp_ok;
        n_size_bad  = i_item.start_of_file ? 1'b0 : r_size_bad;
        n_c0        = r_c0;
        n_c1p1      = r_c1p1;
        n_xoff      = r_xoff;
        n_r0        = r_r0;
        n_r1p1      = r_r1p1;
        n_yoff      = r_yoff;
        n_w3        = r_w3;
        n_row_bytes = r_row_bytes;
        n_bir       = r_bir;
        n_bip       = r_bip;
        n_col       = r_col;
        n_row_rev   = r_row_rev;
        n_blue      = r_blue;
        n_green     = r_green;
        op_emit     = 1'b0;

        o_op.kind         = KIND_PIXEL;
        o_op.blue         = r_blue;
        o_op.green        = r_green;
        o_op.red          = b;
        o_op.pos_x        = r_xoff + r_col;
        o_op.pos_y        = r_yoff + r_row_rev;
        o_op.end_of_image = (r_row_rev == r_r0) && (({1'b0, r_col} + 13'd1) == r_c1p1);

        case (eff_phase)
            PH_MAGIC: begin
                if (magic_bad) begin
                    op_emit   = 1'b1;
                    o_op.kind = KIND_NOT_BMP;
                end else begin
                    n_pos = eff_pos + 32'd1;
                end
            end
            PH_HEADER: begin
                n_shift = {b, r_shift[31:8]};
                n_pos   = r_pos + 32'd1;
                case (r_pos)
                    POS_OFFSET_END: n_pix_off = n_shift;
                    POS_WIDTH_END: begin
                        n_size_bad = r_size_bad || dim_bad(n_shift);
                        n_width    = n_shift[12:0];
                    end
                    POS_HEIGHT_END: begin
                        n_size_bad = r_size_bad || dim_bad(n_shift);
                        n_height   = n_shift[12:0];
                    end
                    POS_DEPTH_END: n_depth_ok = n_shift[31:16] == DEPTH_BGR24;
                    POS_COMP_END:  n_comp_ok  = n_shift == 32'd0;
                    POS_HEADER_END: begin
                        if (hdr_bad) begin
                            op_emit   = 1'b1;
                            o_op.kind = KIND_UNSUPPORTED;
                        end else begin
                            n_c0        = bx_c0;
                            n_c1p1      = bx_c1p1;
                            n_xoff      = bx_x0 - bx_c0;
                            n_r0        = by_r0;
                            n_r1p1      = by_r1p1;
                            n_yoff      = by_y0 - by_r0;
                            n_w3        = w3_calc;
                            n_row_bytes = (w3_calc + 14'd3) & ~14'd3;
                            n_row_rev   = 12'(r_height - 13'd1);
                            n_bir       = 14'd0;
                            n_bip       = 2'd0;
                            n_col       = 12'd0;
                        end
                    end
                    default: ;
                endcase
            end
            PH_SKIP: begin
                if (skip_wait) begin
                    n_pos = r_pos + 32'd1;
                end
            end
            default: ;
        endcase

        if (pix_mode) begin
            if (in_data) begin
                case (r_bip)
                    2'd0: begin
                        n_blue = b;
                        n_bip  = 2'd1;
                    end
                    2'd1: begin
                        n_green = b;
                        n_bip   = 2'd2;
                    end
                    default: begin
                        op_emit = keep;
                        n_col   = r_col + 12'd1;
                        n_bip   = 2'd0;
                    end
                endcase
            end
            n_bir = bir_inc;
            if (row_end) begin
                n_bir = 14'd0;
                n_col = 12'd0;
                n_bip = 2'd0;
                if (r_row_rev != 12'd0) begin
                    n_row_rev = r_row_rev - 12'd1;
                end
            end
        end

        if (o_op.kind != KIND_PIXEL) begin
            o_op.blue         = 8'd0;
            o_op.green        = 8'd0;
            o_op.red          = 8'd0;
            o_op.pos_x        = 12'd0;
            o_op.pos_y        = 12'd0;
            o_op.end_of_image = 1'b0;
        end
    end

    assign o_op_valid = i_accept && op_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC;
            r_pos      <= 32'd0;
            r_size_bad <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_size_bad <= n_size_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_shift     <= n_shift;
            r_pix_off   <= n_pix_off;
            r_width     <= n_width;
            r_height    <= n_height;
            r_depth_ok  <= n_depth_ok;
            r_comp_ok   <= n_comp_ok;
            r_c0        <= n_c0;
            r_c1p1      <= n_c1p1;
            r_xoff      <= n_xoff;
            r_r0        <= n_r0;
            r_r1p1      <= n_r1p1;
            r_yoff      <= n_yoff;
            r_w3        <= n_w3;
            r_row_bytes <= n_row_bytes;
            r_bir       <= n_bir;
            r_bip       <= n_bip;
            r_col       <= n_col;
            r_row_rev   <= n_row_rev;
            r_blue      <= n_blue;
            r_green     <= n_green;
        end
    end

    `BCR_ASSERT_NXT(a_status_ends_file, o_op_valid && (o_op.kind != KIND_PIXEL), r_phase == PH_DONE, "status beat left parser active")
    `BCR_ASSERT_IMP(a_bip_range, r_phase == PH_PIXEL, r_bip != 2'd3, "byte-in-pixel out of range")
    `BCR_ASSERT_IMP(a_row_walk, r_phase == PH_PIXEL, r_bir < r_row_bytes, "row byte count overran row")

endmodule

[rtl/core/bcr_queue.sv]
// ----------------------------------------------------------------------------
// bcr_queue
// Two-entry queue of classified beats between parser and output stage.
// ----------------------------------------------------------------------------
module bcr_queue
    import bcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_op
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

[rtl/core/bcr_back.sv]
// ----------------------------------------------------------------------------
// bcr_back
// Output stage: RGB565 packing and a two-entry result buffer.
// ----------------------------------------------------------------------------
`include "bmp24_crop_to_rgb565_top_defines.svh"

module bcr_back
    import bcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_op_empty,
    input  t_op  i_op,
    output logic o_op_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_result
);

    t_out       r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       out_pop;
    logic       take;
    t_out       conv;

    assign out_pop  = i_pop && (r_cnt != 2'd0);
    assign take     = !i_op_empty && ((r_cnt != 2'd2) || out_pop);
    assign o_op_pop = take;
    assign o_empty  = r_cnt == 2'd0;
    assign o_result = r_buf[r_rd_ptr];

    always_comb begin
        conv.kind         = i_op.kind;
        conv.pixel_color  = to_rgb565(i_op.red, i_op.green, i_op.blue);
        conv.pos_x        = i_op.pos_x;
        conv.pos_y        = i_op.pos_y;
        conv.end_of_image = i_op.end_of_image;
        if (i_op.kind != KIND_PIXEL) begin
            conv.pixel_color = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (take) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({take, out_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_buf[r_wr_ptr] <= conv;
        end
    end

    `BCR_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt != 2'd3, "result buffer count overflow")
    `BCR_ASSERT_NXT(a_fill, (r_cnt == 2'd0) && take, !o_empty, "taken beat not visible")
    `BCR_ASSERT_NXT(a_drain, (r_cnt == 2'd1) && out_pop && !take, o_empty, "popped beat still shown")
    `BCR_ASSERT_IMP(a_status_clean, !o_empty && (o_result.kind != KIND_PIXEL), (o_result.pixel_color == 16'd0) && !o_result.end_of_image, "status beat carries pixel data")

endmodule

[rtl/core/bmp24_crop_to_rgb565_top.sv]
// ----------------------------------------------------------------------------
// bmp24_crop_to_rgb565_top: one file byte per cycle while not full.
// Parser stalls (full) only when its two-entry beat queue is full of unread beats.
// Synchronous active-low reset: parser waits for 'BM', display area 320 x 240.
// ----------------------------------------------------------------------------
module bmp24_crop_to_rgb565_top
    import bcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  t_in         i_item,
    output logic        empty,
    input  logic        pop,
    output t_out        o_result
);

    t_cfg cfg;
    logic accept;
    logic op_valid;
    t_op  op_in;
    t_op  op_out;
    logic op_empty;
    logic op_pop;

    assign accept = push && !full;

    bcr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg      (cfg),
        .o_op_valid (op_valid),
        .o_op       (op_in)
    );

    bcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_valid),
        .i_op    (op_in),
        .o_full  (full),
        .i_pop   (op_pop),
        .o_empty (op_empty),
        .o_op    (op_out)
    );

    bcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op       (op_out),
        .o_op_pop   (op_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule
